[rtl/led_pattern_sequencer_assert.svh]
// Assertion macros shared by the LED pattern sequencer modules.
// Each macro checks on the rising edge of the given clock and is switched off
// while the active-low reset is asserted.
`ifndef LED_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_PATTERN_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lps_pkg.sv]
package lps_pkg;

    // Number of valid samples that make up one averaging window.
    localparam int WINDOW_LENGTH = 10;

    // Window sum width: holds WINDOW_LENGTH signed 16-bit samples.
    localparam int SUM_W = 16 + $clog2(WINDOW_LENGTH);
    // Sample counter width: holds the values 0 to WINDOW_LENGTH.
    localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);

    // Reciprocal for the exact truncating divide of a window sum magnitude.
    localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    // Item modes.
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_SELECT = 2'd2;

    // Pattern codes.
    localparam logic [2:0] PAT_OFF   = 3'd0;
    localparam logic [2:0] PAT_SLOW  = 3'd1;
    localparam logic [2:0] PAT_FAST  = 3'd2;
    localparam logic [2:0] PAT_HEART = 3'd3;
    localparam logic [2:0] PAT_SOS   = 3'd4;
    localparam logic [2:0] PAT_COUNT = 3'd5;
    localparam logic [2:0] PAT_LAST  = PAT_COUNT;

    // Configuration register indexes.
    localparam logic [2:0] CFG_VALID_MIN       = 3'd0;
    localparam logic [2:0] CFG_VALID_MAX       = 3'd1;
    localparam logic [2:0] CFG_HOT_AVERAGE     = 3'd2;
    localparam logic [2:0] CFG_COLD_AVERAGE    = 3'd3;
    localparam logic [2:0] CFG_FAST_RATE_ABOVE = 3'd4;
    localparam logic [2:0] CFG_MID_RATE_ABOVE  = 3'd5;
    localparam logic [2:0] CFG_ADVANCE_TICKS   = 3'd6;

    // Configuration reset values.
    localparam logic signed [15:0] RST_VALID_MIN       = 16'sd0;
    localparam logic signed [15:0] RST_VALID_MAX       = 16'sd12800;
    localparam logic signed [15:0] RST_HOT_AVERAGE     = 16'sd8960;
    localparam logic signed [15:0] RST_COLD_AVERAGE    = 16'sd3840;
    localparam logic signed [15:0] RST_FAST_RATE_ABOVE = 16'sd10240;
    localparam logic signed [15:0] RST_MID_RATE_ABOVE  = 16'sd6400;
    localparam logic [7:0]         RST_ADVANCE_TICKS   = 8'd50;

    // Tick periods per pattern, in ms.
    localparam logic [9:0] TICK_MS_OFF   = 10'd1000;
    localparam logic [9:0] TICK_MS_SLOW  = 10'd1000;
    localparam logic [9:0] TICK_MS_FAST  = 10'd200;
    localparam logic [9:0] TICK_MS_HEART = 10'd100;
    localparam logic [9:0] TICK_MS_SOS   = 10'd1;
    localparam logic [9:0] TICK_MS_COUNT = 10'd300;

    // Morse timing: lit time of a dash and a dot, pause after the whole word.
    localparam logic [9:0] HOLD_MS_DASH = 10'd600;
    localparam logic [9:0] HOLD_MS_DOT  = 10'd200;
    localparam logic [9:0] SOS_PAUSE_MS = 10'd1000;
    localparam logic [3:0] MORSE_LAST       = 4'd8;
    localparam logic [3:0] MORSE_DASH_FIRST = 4'd3;
    localparam logic [3:0] MORSE_DASH_LAST  = 4'd5;

    // Step counter wraps after this value.
    localparam logic [5:0] STEP_LAST = 6'd39;

    // Sampling periods, in ms.
    localparam logic [10:0] SAMPLE_MS_FAST = 11'd500;
    localparam logic [10:0] SAMPLE_MS_MID  = 11'd1000;
    localparam logic [10:0] SAMPLE_MS_SLOW = 11'd2000;

    // One input beat.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] sample;
        logic [2:0]         pattern_sel;
    } item_t;

    // Configuration register file.
    typedef struct packed {
        logic signed [15:0] valid_min;
        logic signed [15:0] valid_max;
        logic signed [15:0] hot_average;
        logic signed [15:0] cold_average;
        logic signed [15:0] fast_rate_above;
        logic signed [15:0] mid_rate_above;
        logic [7:0]         advance_ticks;
    } cfg_t;

    // Result of one step, before the window mean is formed.
    typedef struct packed {
        logic [2:0]             leds;
        logic [9:0]             hold_ms;
        logic [9:0]             pause_ms;
        logic [9:0]             tick_period_ms;
        logic [2:0]             pattern_now;
        logic [31:0]            change_count;
        logic                   sample_ok;
        logic [10:0]            sample_period_ms;
        logic                   average_ready;
        logic signed [SUM_W-1:0] window_sum;
    } step_t;

endpackage

[rtl/lps_engine.sv]
`include "led_pattern_sequencer_assert.svh"

module lps_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  lps_pkg::item_t item,
    input  lps_pkg::cfg_t  cfg,
    output lps_pkg::step_t res
);
    import lps_pkg::*;

    // Engine state.
    logic [2:0]              pattern_reg, pattern_next;
    logic                    toggle_reg, toggle_next;
    logic [5:0]              step_count_reg, step_count_next;
    logic [7:0]              tick_count_reg, tick_count_next;
    logic [3:0]              morse_pos_reg, morse_pos_next;
    logic signed [SUM_W-1:0] sample_sum_reg, sample_sum_next;
    logic [CNT_W-1:0]        sample_number_reg, sample_number_next;
    logic [31:0]             changes_reg, changes_next;

    // Helpers for the step.
    logic signed [15:0]      smp;
    logic [7:0]              tick_inc;
    logic [5:0]              step_inc;
    logic [3:0]              heart_phase;
    logic                    heart_on;
    logic [3:0]              morse_inc;
    logic                    morse_dash;
    logic signed [SUM_W-1:0] sum_add;
    logic [CNT_W-1:0]        number_inc;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W:0]   hot_limit;
    logic signed [SUM_W:0]   cold_limit;
    logic                    in_range;
    logic                    change;
    logic [2:0]              change_to;

    assign smp = item.sample;

    // Counters and wrap points.
    assign tick_inc = tick_count_reg + 8'd1;
    assign step_inc = (step_count_reg == STEP_LAST) ? 6'd0 : step_count_reg + 6'd1;
    assign morse_inc = (morse_pos_reg >= MORSE_LAST) ? 4'd0 : morse_pos_reg + 4'd1;
    assign morse_dash = morse_pos_reg inside {[MORSE_DASH_FIRST:MORSE_DASH_LAST]};

    // Heartbeat phase is the step count modulo ten; the count stays below forty.
    always_comb
    begin
        if (step_count_reg >= 6'd30)
        begin
            heart_phase = 4'(step_count_reg - 6'd30);
        end
        else if (step_count_reg >= 6'd20)
        begin
            heart_phase = 4'(step_count_reg - 6'd20);
        end
        else if (step_count_reg >= 6'd10)
        begin
            heart_phase = 4'(step_count_reg - 6'd10);
        end
        else
        begin
            heart_phase = step_count_reg[3:0];
        end
    end

    assign heart_on = heart_phase inside {[4'd0:4'd1], [4'd3:4'd4]};

    // Window accumulation and exact threshold products.
    assign sum_add = sample_sum_reg + SUM_W'(smp);
    assign number_inc = sample_number_reg + CNT_W'(1);
    assign sum_wide = (SUM_W + 1)'(sum_add);
    assign hot_limit = (SUM_W + 1)'(cfg.hot_average) * (SUM_W + 1)'(WINDOW_LENGTH);
    assign cold_limit = (SUM_W + 1)'(cfg.cold_average) * (SUM_W + 1)'(WINDOW_LENGTH);
    assign in_range = (smp >= cfg.valid_min) && (smp <= cfg.valid_max);

    // One step of the engine for the item in the input register.
    always_comb
    begin
        pattern_next       = pattern_reg;
        toggle_next        = toggle_reg;
        step_count_next    = step_count_reg;
        tick_count_next    = tick_count_reg;
        morse_pos_next     = morse_pos_reg;
        sample_sum_next    = sample_sum_reg;
        sample_number_next = sample_number_reg;
        changes_next       = changes_reg;
        change             = 1'b0;
        change_to          = pattern_reg;
        res                = '0;

        case (item.mode)
            MODE_TICK:
            begin
                case (pattern_reg)
                    PAT_OFF:
                    begin
                        res.tick_period_ms = TICK_MS_OFF;
                    end
                    PAT_SLOW:
                    begin
                        toggle_next = ~toggle_reg;
                        res.leds = {2'b00, ~toggle_reg};
                        res.tick_period_ms = TICK_MS_SLOW;
                    end
                    PAT_FAST:
                    begin
                        toggle_next = ~toggle_reg;
                        res.leds = {1'b0, ~toggle_reg, 1'b0};
                        res.tick_period_ms = TICK_MS_FAST;
                    end
                    PAT_HEART:
                    begin
                        res.leds = heart_on ? 3'b100 : 3'b000;
                        step_count_next = step_inc;
                        res.tick_period_ms = TICK_MS_HEART;
                    end
                    PAT_SOS:
                    begin
                        res.leds = 3'b111;
                        res.hold_ms = morse_dash ? HOLD_MS_DASH : HOLD_MS_DOT;
                        morse_pos_next = morse_inc;
                        res.pause_ms = (morse_inc == 4'd0) ? SOS_PAUSE_MS : 10'd0;
                        res.tick_period_ms = TICK_MS_SOS;
                    end
                    PAT_COUNT:
                    begin
                        res.leds = step_count_reg[2:0];
                        step_count_next = step_inc;
                        res.tick_period_ms = TICK_MS_COUNT;
                    end
                    default:
                    begin
                    end
                endcase

                // Automatic advance every advance_ticks ticks.
                tick_count_next = tick_inc;
                if (tick_inc == cfg.advance_ticks)
                begin
                    tick_count_next = 8'd0;
                    change = 1'b1;
                    change_to = (pattern_reg >= PAT_LAST) ? PAT_OFF : pattern_reg + 3'd1;
                end
            end
            MODE_SAMPLE:
            begin
                res.sample_ok = in_range;
                if (in_range)
                begin
                    sample_sum_next = sum_add;
                    sample_number_next = number_inc;
                    if (number_inc >= CNT_W'(WINDOW_LENGTH))
                    begin
                        res.average_ready = 1'b1;
                        res.window_sum = sum_add;
                        if (sum_wide > hot_limit)
                        begin
                            change = 1'b1;
                            change_to = PAT_FAST;
                        end
                        else if (sum_wide < cold_limit)
                        begin
                            change = 1'b1;
                            change_to = PAT_SOS;
                        end
                        sample_sum_next = '0;
                        sample_number_next = '0;
                    end
                end

                // Adaptive sampling period.
                if (smp > cfg.fast_rate_above)
                begin
                    res.sample_period_ms = SAMPLE_MS_FAST;
                end
                else if (smp > cfg.mid_rate_above)
                begin
                    res.sample_period_ms = SAMPLE_MS_MID;
                end
                else
                begin
                    res.sample_period_ms = SAMPLE_MS_SLOW;
                end
            end
            MODE_SELECT:
            begin
                if (item.pattern_sel <= PAT_LAST)
                begin
                    change = 1'b1;
                    change_to = item.pattern_sel;
                end
            end
            default:
            begin
            end
        endcase

        // A pattern change resets the step count and the toggle and is counted.
        if (change)
        begin
            pattern_next = change_to;
            step_count_next = 6'd0;
            toggle_next = 1'b0;
            changes_next = changes_reg + 32'd1;
        end

        res.pattern_now = pattern_next;
        res.change_count = changes_next;
    end

    // State registers advance once per stepped beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg       <= PAT_SLOW;
            toggle_reg        <= 1'b0;
            step_count_reg    <= 6'd0;
            tick_count_reg    <= 8'd0;
            morse_pos_reg     <= 4'd0;
            sample_sum_reg    <= '0;
            sample_number_reg <= '0;
            changes_reg       <= 32'd0;
        end
        else if (step_en)
        begin
            pattern_reg       <= pattern_next;
            toggle_reg        <= toggle_next;
            step_count_reg    <= step_count_next;
            tick_count_reg    <= tick_count_next;
            morse_pos_reg     <= morse_pos_next;
            sample_sum_reg    <= sample_sum_next;
            sample_number_reg <= sample_number_next;
            changes_reg       <= changes_next;
        end
    end

    // The Morse position and the step count stay inside their wrap ranges.
    `LPS_ASSERT_IMPL(a_morse_range, clk, rst_n, 1'b1,
                     morse_pos_reg <= MORSE_LAST, "Morse position out of range")
    `LPS_ASSERT_IMPL(a_step_range, clk, rst_n, 1'b1,
                     step_count_reg <= STEP_LAST, "step count out of range")

    // Without a step the pattern and the change count hold.
    `LPS_ASSERT_NEXT(a_idle_holds, clk, rst_n, !step_en,
                     $stable(changes_reg) && $stable(pattern_reg),
                     "state moved without a step")

endmodule

[rtl/lps_mean.sv]
module lps_mean (
    input  logic signed [lps_pkg::SUM_W-1:0] window_sum,
    output logic signed [15:0]               average
);
    import lps_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic                negative;
    logic [SUM_W-1:0]    magnitude;
    logic [PROD_W-1:0]   product;
    logic [15:0]         quotient;

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign negative = window_sum[SUM_W-1];
    assign magnitude = negative ? SUM_W'(-window_sum) : SUM_W'(window_sum);

    // The rounded-up reciprocal gives the exact quotient for every magnitude.
    assign product = PROD_W'(magnitude) * PROD_W'(RECIP);
    assign quotient = product[RECIP_SHIFT +: 16];

    assign average = negative ? -$signed(quotient) : $signed(quotient);

endmodule

[rtl/led_pattern_sequencer.sv]
// Three-LED pattern engine. Each input beat is a pattern tick, a temperature
// sample or a pattern select, and each gives exactly one result beat. The
// block takes one beat every cycle while item_stall is low. A result moves
// from the input register through the engine step into a middle register,
// then through the window mean into the output register, where it waits
// until it is taken. All three stages move together: while a result waits
// with result_stall high, item_stall is high in the same cycle, and the
// block otherwise keeps accepting at full rate. Configuration writes take
// effect on the next clock edge and should only be issued while no beat is
// in flight.
`include "led_pattern_sequencer_assert.svh"

module led_pattern_sequencer (
    input  logic               clk,
    input  logic               rst_n,

    // Configuration write port.
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    // Item channel.
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         mode,
    input  logic signed [15:0] sample,
    input  logic [2:0]         pattern_sel,

    // Result channel.
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         leds,
    output logic [9:0]         hold_ms,
    output logic [9:0]         pause_ms,
    output logic [9:0]         tick_period_ms,
    output logic [2:0]         pattern_now,
    output logic [31:0]        change_count,
    output logic               sample_ok,
    output logic [10:0]        sample_period_ms,
    output logic signed [15:0] average,
    output logic               average_ready
);
    import lps_pkg::*;

    cfg_t               cfg_reg;
    logic               advance;
    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               mid_valid_reg;
    step_t              mid_step_reg;
    step_t              step_res;
    logic               result_valid_reg;
    step_t              out_step_reg;
    logic signed [15:0] mean;
    logic signed [15:0] average_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.valid_min       <= RST_VALID_MIN;
            cfg_reg.valid_max       <= RST_VALID_MAX;
            cfg_reg.hot_average     <= RST_HOT_AVERAGE;
            cfg_reg.cold_average    <= RST_COLD_AVERAGE;
            cfg_reg.fast_rate_above <= RST_FAST_RATE_ABOVE;
            cfg_reg.mid_rate_above  <= RST_MID_RATE_ABOVE;
            cfg_reg.advance_ticks   <= RST_ADVANCE_TICKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VALID_MIN:       cfg_reg.valid_min       <= cfg_data;
                CFG_VALID_MAX:       cfg_reg.valid_max       <= cfg_data;
                CFG_HOT_AVERAGE:     cfg_reg.hot_average     <= cfg_data;
                CFG_COLD_AVERAGE:    cfg_reg.cold_average    <= cfg_data;
                CFG_FAST_RATE_ABOVE: cfg_reg.fast_rate_above <= cfg_data;
                CFG_MID_RATE_ABOVE:  cfg_reg.mid_rate_above  <= cfg_data;
                CFG_ADVANCE_TICKS:   cfg_reg.advance_ticks   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // The pipeline moves whenever the output register is empty or being taken.
    assign advance = !result_valid_reg || !result_stall;
    assign item_stall = !advance;

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            mid_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg     <= item_valid;
            mid_valid_reg    <= in_valid_reg;
            result_valid_reg <= mid_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            in_item_reg.mode        <= mode;
            in_item_reg.sample      <= sample;
            in_item_reg.pattern_sel <= pattern_sel;
        end
        if (advance && in_valid_reg)
        begin
            mid_step_reg <= step_res;
        end
        if (advance && mid_valid_reg)
        begin
            out_step_reg <= mid_step_reg;
            average_reg  <= mid_step_reg.average_ready ? mean : 16'sd0;
        end
    end

    lps_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance && in_valid_reg),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    lps_mean u_mean (
        .window_sum (mid_step_reg.window_sum),
        .average    (mean)
    );

    // Result beat.
    assign result_valid     = result_valid_reg;
    assign leds             = out_step_reg.leds;
    assign hold_ms          = out_step_reg.hold_ms;
    assign pause_ms         = out_step_reg.pause_ms;
    assign tick_period_ms   = out_step_reg.tick_period_ms;
    assign pattern_now      = out_step_reg.pattern_now;
    assign change_count     = out_step_reg.change_count;
    assign sample_ok        = out_step_reg.sample_ok;
    assign sample_period_ms = out_step_reg.sample_period_ms;
    assign average          = average_reg;
    assign average_ready    = out_step_reg.average_ready;

    // A finished window always comes from a valid sample, and the mean is
    // zero on every other result.
    `LPS_ASSERT_IMPL(a_ready_needs_ok, clk, rst_n, result_valid_reg && average_ready,
                     sample_ok, "window closed on an invalid sample")
    `LPS_ASSERT_IMPL(a_mean_zero, clk, rst_n, result_valid_reg && !average_ready,
                     average == 16'sd0, "mean set without a finished window")

endmodule

[tb/sv/tb.sv]
module tb;
    import lps_pkg::*;

    // Depth of the block from item acceptance to result.
    localparam int PIPE_LATENCY = 3;
    // The fourth mode code has no meaning and is ignored by the block.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // One result beat as the engine should produce it.
    typedef struct packed {
        logic [2:0]         leds;
        logic [9:0]         hold_ms;
        logic [9:0]         pause_ms;
        logic [9:0]         tick_period_ms;
        logic [2:0]         pattern_now;
        logic [31:0]        change_count;
        logic               sample_ok;
        logic [10:0]        sample_period_ms;
        logic signed [15:0] average;
        logic               average_ready;
    } led_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = CFG_VALID_MIN;
    logic [15:0]        cfg_data = 16'd0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic [1:0]         mode = MODE_TICK;
    logic signed [15:0] sample = 16'sd0;
    logic [2:0]         pattern_sel = PAT_OFF;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [2:0]         leds;
    logic [9:0]         hold_ms;
    logic [9:0]         pause_ms;
    logic [9:0]         tick_period_ms;
    logic [2:0]         pattern_now;
    logic [31:0]        change_count;
    logic               sample_ok;
    logic [10:0]        sample_period_ms;
    logic signed [15:0] average;
    logic               average_ready;

    // Beats waiting to be sent and results waiting to arrive.
    item_t       pending_items[$];
    led_result_t results_due[$];
    item_t       next_item;
    led_result_t oldest_due;

    int items_sent = 0;
    int results_checked = 0;
    int stimulus_count = 0;
    int send_idle_pct = 10;
    int recv_idle_pct = 10;
    bit saw_mismatch = 1'b0;

    // Engine state and register copy kept by the predictor.
    cfg_t        cfg_now;
    logic [2:0]  eng_pattern = PAT_SLOW;
    logic        eng_toggle = 1'b0;
    logic [5:0]  eng_step = 6'd0;
    logic [7:0]  eng_ticks = 8'd0;
    logic [3:0]  eng_morse = 4'd0;
    int          eng_sum = 0;
    int          eng_count = 0;
    logic [31:0] eng_changes = 32'd0;

    led_pattern_sequencer u_top (.*);

    always #10 clk = ~clk;

    // Any pattern change resets the step count and the toggle, and counts once.
    function automatic void switch_pattern(input logic [2:0] p);
        eng_pattern = p;
        eng_step = 6'd0;
        eng_toggle = 1'b0;
        eng_changes = eng_changes + 32'd1;
    endfunction

    function automatic logic [5:0] next_step(input logic [5:0] s);
        return (s == STEP_LAST) ? 6'd0 : s + 6'd1;
    endfunction

    // Advance the engine by one accepted beat and queue the result it owes.
    function automatic void predict_led_step(input item_t it);
        led_result_t r;
        int s;
        int st;
        int lo;
        int hi;
        r = '0;
        s = $signed(it.sample);
        lo = cfg_now.valid_min;
        hi = cfg_now.valid_max;
        case (it.mode)
            MODE_TICK:
            begin
                case (eng_pattern)
                    PAT_OFF:
                        r.tick_period_ms = TICK_MS_OFF;
                    PAT_SLOW:
                    begin
                        eng_toggle = ~eng_toggle;
                        r.leds = {2'b00, eng_toggle};
                        r.tick_period_ms = TICK_MS_SLOW;
                    end
                    PAT_FAST:
                    begin
                        eng_toggle = ~eng_toggle;
                        r.leds = {1'b0, eng_toggle, 1'b0};
                        r.tick_period_ms = TICK_MS_FAST;
                    end
                    PAT_HEART:
                    begin
                        st = eng_step % 10;
                        r.leds = (st < 2 || (st >= 3 && st < 5)) ? 3'd4 : 3'd0;
                        eng_step = next_step(eng_step);
                        r.tick_period_ms = TICK_MS_HEART;
                    end
                    PAT_SOS:
                    begin
                        r.leds = 3'd7;
                        r.hold_ms = (eng_morse >= MORSE_DASH_FIRST && eng_morse <= MORSE_DASH_LAST)
                            ? HOLD_MS_DASH : HOLD_MS_DOT;
                        // The word ends after its last element and is followed by a pause.
                        if (eng_morse == MORSE_LAST)
                        begin
                            eng_morse = 4'd0;
                            r.pause_ms = SOS_PAUSE_MS;
                        end
                        else
                            eng_morse = eng_morse + 4'd1;
                        r.tick_period_ms = TICK_MS_SOS;
                    end
                    PAT_COUNT:
                    begin
                        r.leds = eng_step[2:0];
                        eng_step = next_step(eng_step);
                        r.tick_period_ms = TICK_MS_COUNT;
                    end
                    default:
                        ;
                endcase
                eng_ticks = eng_ticks + 8'd1;
                if (eng_ticks == cfg_now.advance_ticks)
                begin
                    eng_ticks = 8'd0;
                    switch_pattern((eng_pattern >= PAT_LAST) ? PAT_OFF : eng_pattern + 3'd1);
                end
            end
            MODE_SAMPLE:
            begin
                r.sample_ok = (s >= lo && s <= hi);
                // Only valid samples fill the averaging window.
                if (r.sample_ok)
                begin
                    eng_sum = eng_sum + s;
                    eng_count = eng_count + 1;
                    if (eng_count >= WINDOW_LENGTH)
                    begin
                        r.average = 16'(eng_sum / WINDOW_LENGTH);
                        r.average_ready = 1'b1;
                        if (eng_sum > int'(cfg_now.hot_average) * WINDOW_LENGTH)
                            switch_pattern(PAT_FAST);
                        else if (eng_sum < int'(cfg_now.cold_average) * WINDOW_LENGTH)
                            switch_pattern(PAT_SOS);
                        eng_sum = 0;
                        eng_count = 0;
                    end
                end
                if (s > int'(cfg_now.fast_rate_above))
                    r.sample_period_ms = SAMPLE_MS_FAST;
                else if (s > int'(cfg_now.mid_rate_above))
                    r.sample_period_ms = SAMPLE_MS_MID;
                else
                    r.sample_period_ms = SAMPLE_MS_SLOW;
            end
            MODE_SELECT:
            begin
                if (it.pattern_sel <= PAT_LAST)
                    switch_pattern(it.pattern_sel);
            end
            default:
                ;
        endcase
        r.pattern_now = eng_pattern;
        r.change_count = eng_changes;
        results_due.push_back(r);
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            saw_mismatch = 1'b1;
        end
    endfunction

    // Item driver: a new beat is offered only once the previous one has gone.
    always @(posedge clk)
    begin
        if (rst_n && (!item_valid || !item_stall))
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = pending_items.pop_front();
                items_sent++;
                item_valid  <= 1'b1;
                mode        <= next_item.mode;
                sample      <= next_item.sample;
                pattern_sel <= next_item.pattern_sel;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Monitor: checks result beats, predicts accepted item beats, stalls at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result beat arrived with no result outstanding");
                    saw_mismatch = 1'b1;
                end
                else
                begin
                    oldest_due = results_due.pop_front();
                    check_field("leds", oldest_due.leds, leds);
                    check_field("hold_ms", oldest_due.hold_ms, hold_ms);
                    check_field("pause_ms", oldest_due.pause_ms, pause_ms);
                    check_field("tick_period_ms", oldest_due.tick_period_ms, tick_period_ms);
                    check_field("pattern_now", oldest_due.pattern_now, pattern_now);
                    check_field("change_count", oldest_due.change_count, change_count);
                    check_field("sample_ok", oldest_due.sample_ok, sample_ok);
                    check_field("sample_period_ms", oldest_due.sample_period_ms,
                                sample_period_ms);
                    check_field("average", $signed(oldest_due.average), $signed(average));
                    check_field("average_ready", oldest_due.average_ready, average_ready);
                    results_checked++;
                end
            end
            if (item_valid && !item_stall)
                predict_led_step('{mode: mode, sample: sample, pattern_sel: pattern_sel});
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Ignored beats (unused mode, select out of range) do not count as stimulus.
    function automatic void push_item(input logic [1:0] m, input logic [15:0] s,
                                      input logic [2:0] np);
        item_t it;
        it.mode = m;
        it.sample = s;
        it.pattern_sel = np;
        pending_items.push_back(it);
        if (!(m == MODE_UNUSED || (m == MODE_SELECT && np > PAT_LAST)))
            stimulus_count++;
    endfunction

    // Pull a value into the valid range when the range is sane, and into 16 bits.
    function automatic logic [15:0] fit_sample(input int v);
        int lo;
        int hi;
        lo = cfg_now.valid_min;
        hi = cfg_now.valid_max;
        if (lo <= hi)
        begin
            if (v < lo)
                v = lo;
            if (v > hi)
                v = hi;
        end
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return 16'(v);
    endfunction

    // Samples on and just outside the range limits, the 16-bit extremes, or noise.
    function automatic logic [15:0] edge_sample();
        int lo;
        int hi;
        lo = cfg_now.valid_min;
        hi = cfg_now.valid_max;
        case ($urandom_range(6))
            0: return 16'(lo);
            1: return 16'(hi);
            2: return 16'(lo - 1);
            3: return 16'(hi + 1);
            4: return 16'h8000;
            5: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // A full window of samples, kept in a sane valid range, past or on a threshold, between
    // the thresholds or anywhere in the range, with ticks mixed in now and then.
    function automatic void push_window();
        int kind;
        int lo;
        int hi;
        int hot;
        int cold;
        int v;
        lo = cfg_now.valid_min;
        hi = cfg_now.valid_max;
        hot = cfg_now.hot_average;
        cold = cfg_now.cold_average;
        kind = $urandom_range(5);
        for (int i = 0; i < WINDOW_LENGTH; i++)
        begin
            if ($urandom_range(4) == 0)
                push_item(MODE_TICK, 16'($urandom), 3'($urandom));
            case (kind)
                0: v = (lo <= hi) ? lo + int'($urandom_range(hi - lo)) : $signed(16'($urandom));
                1: v = hot + int'($urandom_range(400, 1));
                2: v = cold - int'($urandom_range(400, 1));
                3: v = hot;
                4: v = cold;
                default: v = (hot + cold) / 2 + int'($urandom_range(200)) - 100;
            endcase
            // Sums sitting exactly on a threshold, or one count either side.
            if (i == WINDOW_LENGTH - 1 && (kind == 3 || kind == 4))
                v = v + int'($urandom_range(2)) - 1;
            push_item(MODE_SAMPLE, fit_sample(v), 3'($urandom));
        end
    endfunction

    function automatic void push_chunk();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            push_window();
        else if (r < 65)
            repeat ($urandom_range(24, 1))
                push_item(MODE_TICK, 16'($urandom), 3'($urandom));
        else if (r < 77)
            push_item(MODE_SELECT, 16'($urandom), 3'($urandom));
        else if (r < 90)
            push_item(MODE_SAMPLE, edge_sample(), 3'($urandom));
        else if (r < 95)
            push_item(MODE_UNUSED, 16'($urandom), 3'($urandom));
        else
            push_item(2'($urandom), 16'($urandom), 3'($urandom));
    endfunction

    // Wait until every sent beat has its result, then let the pipeline empty.
    task automatic settle();
        while (pending_items.size() != 0 || results_checked != items_sent)
            @(posedge clk);
        repeat (2 * PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_VALID_MIN:       cfg_now.valid_min = data;
            CFG_VALID_MAX:       cfg_now.valid_max = data;
            CFG_HOT_AVERAGE:     cfg_now.hot_average = data;
            CFG_COLD_AVERAGE:    cfg_now.cold_average = data;
            CFG_FAST_RATE_ABOVE: cfg_now.fast_rate_above = data;
            CFG_MID_RATE_ABOVE:  cfg_now.mid_rate_above = data;
            CFG_ADVANCE_TICKS:   cfg_now.advance_ticks = data[7:0];
            default:             ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] vmin, input logic [15:0] vmax,
                               input logic [15:0] hot, input logic [15:0] cold,
                               input logic [15:0] fast, input logic [15:0] mid,
                               input logic [7:0] adv);
        write_reg(CFG_VALID_MIN, vmin);
        write_reg(CFG_VALID_MAX, vmax);
        write_reg(CFG_HOT_AVERAGE, hot);
        write_reg(CFG_COLD_AVERAGE, cold);
        write_reg(CFG_FAST_RATE_ABOVE, fast);
        write_reg(CFG_MID_RATE_ABOVE, mid);
        write_reg(CFG_ADVANCE_TICKS, {8'd0, adv});
        cfg_we <= 1'b0;
    endtask

    // Thresholds drawn inside a random valid range; advance mostly short.
    task automatic load_random_config();
        int lo;
        int hi;
        int adv;
        lo = int'($urandom_range(4000)) - 2000;
        hi = lo + int'($urandom_range(14000));
        adv = ($urandom_range(1) == 0) ? int'($urandom_range(12, 1))
                                       : int'($urandom_range(255, 1));
        load_config(16'(lo), 16'(hi),
                    16'(lo + int'($urandom_range(hi - lo))),
                    16'(lo + int'($urandom_range(hi - lo))),
                    16'(lo + int'($urandom_range(hi - lo))),
                    16'(lo + int'($urandom_range(hi - lo))),
                    8'(adv));
    endtask

    // One phase of random stimulus, optionally holding the sender halfway
    // until the block has returned every result.
    task automatic run_phase(input int n, input bit pause_midway);
        int goal;
        goal = stimulus_count + n / 2;
        while (stimulus_count < goal)
            push_chunk();
        if (pause_midway)
            settle();
        goal = stimulus_count + (n - n / 2);
        while (stimulus_count < goal)
            push_chunk();
        settle();
    endtask

    initial
    begin
        cfg_now.valid_min = RST_VALID_MIN;
        cfg_now.valid_max = RST_VALID_MAX;
        cfg_now.hot_average = RST_HOT_AVERAGE;
        cfg_now.cold_average = RST_COLD_AVERAGE;
        cfg_now.fast_rate_above = RST_FAST_RATE_ABOVE;
        cfg_now.mid_rate_above = RST_MID_RATE_ABOVE;
        cfg_now.advance_ticks = RST_ADVANCE_TICKS;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every pattern selected and ticked, repeated and ignored
        // selects, the unused mode, samples on and just past the range limits, 16-bit extremes.
        push_item(MODE_TICK, 16'h0000, PAT_OFF);
        push_item(MODE_TICK, 16'hFFFF, 3'd7);
        for (int p = PAT_OFF; p <= PAT_LAST; p++)
        begin
            push_item(MODE_SELECT, 16'h0000, 3'(p));
            push_item(MODE_TICK, 16'h5555, 3'd2);
        end
        push_item(MODE_SELECT, 16'hAAAA, PAT_COUNT);
        push_item(MODE_SELECT, 16'h0000, 3'd6);
        push_item(MODE_SELECT, 16'h0000, 3'd7);
        push_item(MODE_UNUSED, 16'h8000, 3'd7);
        push_item(MODE_SAMPLE, 16'h8000, PAT_OFF);
        push_item(MODE_SAMPLE, 16'h7FFF, 3'd7);
        push_item(MODE_SAMPLE, 16'(RST_VALID_MIN), PAT_OFF);
        push_item(MODE_SAMPLE, 16'(RST_VALID_MAX), PAT_OFF);
        push_item(MODE_SAMPLE, 16'(RST_VALID_MIN - 16'sd1), PAT_OFF);
        push_item(MODE_SAMPLE, 16'(RST_VALID_MAX + 16'sd1), PAT_OFF);
        settle();

        // Widest valid range, thresholds that never fire, advance every tick;
        // no idling on either side for this long stretch.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 8'd1);
        run_phase(150, 1'b0);

        // Crossed range so no sample is valid, slowest advance.
        send_idle_pct = 10;
        recv_idle_pct = 10;
        load_config(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 8'd255);
        run_phase(100, 1'b0);

        // Reset thresholds, advance lowered below the running tick count.
        load_config(RST_VALID_MIN, RST_VALID_MAX, RST_HOT_AVERAGE, RST_COLD_AVERAGE,
                    RST_FAST_RATE_ABOVE, RST_MID_RATE_ABOVE, 8'd2);
        run_phase(125, 1'b1);

        repeat (6)
        begin
            load_random_config();
            run_phase(105, 1'b0);
        end

        if (!saw_mismatch && results_due.size() == 0)
            $display("led_pattern_sequencer: match");
        else
            $display("led_pattern_sequencer: mismatch");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("led_pattern_sequencer: mismatch");
        $finish;
    end

endmodule
